// File: sv/hbsd_pkg.sv
// hbsd_pkg: shared types, constants and helpers for the dual h-bridge stick driver
// used by hbsd_cfg, hbsd_bridge and dual_hbridge_stick_driver_top; no dependencies
package hbsd_pkg;

  // field widths
  localparam int DUTY_W  = 10;
  localparam int STICK_W = 11;
  localparam int TIME_W  = 32;
  localparam int STBY_W  = 16;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;
  localparam int CALC_W  = 15;

  // stick calibration points
  localparam int STICK_MIN = 172;
  localparam int STICK_MID = 992;
  localparam int STICK_MAX = 1811;
  localparam logic [STICK_W-1:0] STICK_MID_V = STICK_W'(STICK_MID);
  localparam logic [STICK_W-1:0] STICK_MIN_V = STICK_W'(STICK_MIN);

  // duty limits and register reset values
  localparam int DUTY_LIMIT = 1000;
  localparam logic signed [CALC_W-1:0] DUTY_LIMIT_S = CALC_W'(DUTY_LIMIT);
  localparam logic [DUTY_W-1:0] SLEEP_DUTY_RST = DUTY_W'(0);
  localparam logic [DUTY_W-1:0] FULL_DUTY_RST  = DUTY_W'(1000);
  localparam logic [STBY_W-1:0] STANDBY_RST    = STBY_W'(5000);

  // register indexes (byte address bits [3:2])
  localparam logic [1:0] REG_SLEEP_DUTY = 2'd0;
  localparam logic [1:0] REG_FULL_DUTY  = 2'd1;
  localparam logic [1:0] REG_STANDBY_MS = 2'd2;

  // operation codes
  localparam logic OP_UPDATE   = 1'b0;
  localparam logic OP_FAILSAFE = 1'b1;

  // rounded division by 2*span via reciprocal multiply, exact for numerators below 2^22
  localparam int RECIP_SHIFT = 33;
  localparam int RECIP_W     = 23;
  localparam int K_W         = 34;
  localparam int BIAS_W      = 33;
  localparam int PROD_W      = 46;
  localparam int Q_W         = PROD_W - RECIP_SHIFT;
  localparam longint SPAN_UP = STICK_MAX - STICK_MID;
  localparam longint SPAN_DN = STICK_MID - STICK_MIN;
  localparam longint RECIP_UP_L = ((64'sd1 <<< RECIP_SHIFT) + 2 * SPAN_UP - 1) / (2 * SPAN_UP);
  localparam longint RECIP_DN_L = ((64'sd1 <<< RECIP_SHIFT) + 2 * SPAN_DN - 1) / (2 * SPAN_DN);
  localparam logic [RECIP_W-1:0] RECIP_UP = RECIP_W'(RECIP_UP_L);
  localparam logic [RECIP_W-1:0] RECIP_DN = RECIP_W'(RECIP_DN_L);
  localparam logic [BIAS_W-1:0]  BIAS_UP  = BIAS_W'(SPAN_UP * RECIP_UP_L);
  localparam logic [BIAS_W-1:0]  BIAS_DN  = BIAS_W'(SPAN_DN * RECIP_DN_L);

  // configuration as seen by the datapath
  typedef struct packed {
    logic [DUTY_W-1:0] sleep_duty;
    logic [DUTY_W-1:0] full_duty;
    logic [STBY_W-1:0] standby_ms;
    logic [K_W-1:0]    k_up;
    logic [K_W-1:0]    k_dn;
  } hbsd_cfg_t;

  function automatic logic [DUTY_W-1:0] clamp_duty(input logic signed [CALC_W-1:0] v);
    logic [DUTY_W-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > DUTY_LIMIT_S) begin
      r = DUTY_W'(DUTY_LIMIT);
    end else begin
      r = v[DUTY_W-1:0];
    end
    return r;
  endfunction

endpackage

// File: sv/hbsd_cfg.sv
// hbsd_cfg: apb register file plus derived map slope constants
// depends on hbsd_pkg
module hbsd_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [hbsd_pkg::ADDR_W-1:0]   paddr,
  input  logic [hbsd_pkg::DATA_W-1:0]   pwdata,
  output logic [hbsd_pkg::DATA_W-1:0]   prdata,
  output hbsd_pkg::hbsd_cfg_t           cfg
);
  import hbsd_pkg::*;

  logic [DUTY_W-1:0] sleep_r, sleep_nxt;
  logic [DUTY_W-1:0] full_r, full_nxt;
  logic [STBY_W-1:0] stby_r, stby_nxt;
  logic [K_W-1:0]    k_up_r, k_dn_r;
  logic [DUTY_W-1:0] diff;
  logic [K_W-2:0]    kh_up, kh_dn;
  logic              wr;
  logic [1:0]        idx;

  assign wr  = psel & penable & pwrite;
  assign idx = paddr[3:2];

  // register next values, reset values win
  always_comb begin
    sleep_nxt = sleep_r;
    full_nxt  = full_r;
    stby_nxt  = stby_r;
    if (wr) begin
      case (idx)
        REG_SLEEP_DUTY: sleep_nxt = pwdata[DUTY_W-1:0];
        REG_FULL_DUTY:  full_nxt  = pwdata[DUTY_W-1:0];
        REG_STANDBY_MS: stby_nxt  = pwdata[STBY_W-1:0];
        default: ;
      endcase
    end
    if (!rst_n) begin
      sleep_nxt = SLEEP_DUTY_RST;
      full_nxt  = FULL_DUTY_RST;
      stby_nxt  = STANDBY_RST;
    end
  end

  // slope constants follow the duty registers: 2*|full-sleep|*reciprocal
  assign diff  = (full_nxt >= sleep_nxt) ? (full_nxt - sleep_nxt) : (sleep_nxt - full_nxt);
  assign kh_up = (K_W-1)'(diff) * (K_W-1)'(RECIP_UP);
  assign kh_dn = (K_W-1)'(diff) * (K_W-1)'(RECIP_DN);

  always_ff @(posedge clk) begin
    sleep_r <= sleep_nxt;
    full_r  <= full_nxt;
    stby_r  <= stby_nxt;
    k_up_r  <= {kh_up, 1'b0};
    k_dn_r  <= {kh_dn, 1'b0};
  end

  // read back
  always_comb begin
    case (idx)
      REG_SLEEP_DUTY: prdata = DATA_W'(sleep_r);
      REG_FULL_DUTY:  prdata = DATA_W'(full_r);
      REG_STANDBY_MS: prdata = DATA_W'(stby_r);
      default:        prdata = '0;
    endcase
  end

  assign cfg.sleep_duty = sleep_r;
  assign cfg.full_duty  = full_r;
  assign cfg.standby_ms = stby_r;
  assign cfg.k_up       = k_up_r;
  assign cfg.k_dn       = k_dn_r;

endmodule

// File: sv/hbsd_bridge.sv
// hbsd_bridge: both leg duties of one h-bridge from one stick value
// depends on hbsd_pkg; one reciprocal multiplier for the rounded linear map
module hbsd_bridge (
  input  logic [hbsd_pkg::STICK_W-1:0] stick,
  input  logic                         stdby,
  input  hbsd_pkg::hbsd_cfg_t          cfg,
  output logic [hbsd_pkg::DUTY_W-1:0]  leg1,
  output logic [hbsd_pkg::DUTY_W-1:0]  leg2,
  output logic                         moved
);
  import hbsd_pkg::*;

  logic                           up, dn;
  logic [STICK_W-1:0]             d_up;
  logic signed [STICK_W:0]        d_dn;
  logic [STICK_W-1:0]             d_abs;
  logic [K_W-1:0]                 k;
  logic [BIAS_W-1:0]              bias;
  logic                           neg;
  logic [DUTY_W-1:0]              y0;
  logic [PROD_W-1:0]              sum;
  logic [Q_W-1:0]                 q;
  logic signed [CALC_W-1:0]       y0_s, q_s, y;
  logic [DUTY_W-1:0]              map_val, full_c, sleep_c, centre;

  // stick position
  assign up    = stick > STICK_MID_V;
  assign dn    = stick < STICK_MID_V;
  assign moved = up | dn;

  // distance from the line's start point
  assign d_up  = stick - STICK_MID_V;
  assign d_dn  = $signed({1'b0, stick}) - $signed({1'b0, STICK_MIN_V});
  assign d_abs = up ? d_up : (d_dn < 0 ? STICK_W'(-d_dn) : STICK_W'(d_dn));

  // line parameters: above centre runs full to sleep, below runs sleep to full
  assign k    = up ? cfg.k_up : cfg.k_dn;
  assign bias = up ? BIAS_UP : BIAS_DN;
  assign y0   = up ? cfg.full_duty : cfg.sleep_duty;
  assign neg  = up ? (cfg.sleep_duty < cfg.full_duty)
                   : ((d_dn < 0) ^ (cfg.full_duty < cfg.sleep_duty));

  // rounded quotient of |num| by span, halves away from zero
  assign sum = PROD_W'(d_abs) * PROD_W'(k) + PROD_W'(bias);
  assign q   = sum[PROD_W-1:RECIP_SHIFT];

  assign y0_s = $signed(CALC_W'(y0));
  assign q_s  = $signed(CALC_W'(q));
  assign y    = neg ? (y0_s - q_s) : (y0_s + q_s);

  assign map_val = clamp_duty(y);
  assign full_c  = clamp_duty($signed(CALC_W'(cfg.full_duty)));
  assign sleep_c = clamp_duty($signed(CALC_W'(cfg.sleep_duty)));
  assign centre  = stdby ? sleep_c : full_c;

  // leg selection
  always_comb begin
    if (up) begin
      leg1 = full_c;
      leg2 = map_val;
    end else if (dn) begin
      leg1 = map_val;
      leg2 = full_c;
    end else begin
      leg1 = centre;
      leg2 = centre;
    end
  end

endmodule

// File: sv/dual_hbridge_stick_driver_top.sv
// dual_hbridge_stick_driver_top: input register, arming and standby state,
// two bridge units and the result register; depends on hbsd_pkg, hbsd_cfg, hbsd_bridge
// path: an accepted beat waits in the input register, then its result is written to the result register
// throughput: one beat per cycle while out_ready holds, set by the single pass from input to result register
// reset (rst_n low, synchronous): pipeline empty, disarmed, last movement time zero,
// registers back to sleep 0, full 1000, standby 5000
module dual_hbridge_stick_driver_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_operation,
  input  logic [hbsd_pkg::TIME_W-1:0]  in_now_ms,
  input  logic [hbsd_pkg::STICK_W-1:0] in_stick_a,
  input  logic [hbsd_pkg::STICK_W-1:0] in_stick_b,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [hbsd_pkg::DUTY_W-1:0]  out_duty_a1,
  output logic [hbsd_pkg::DUTY_W-1:0]  out_duty_a2,
  output logic [hbsd_pkg::DUTY_W-1:0]  out_duty_b1,
  output logic [hbsd_pkg::DUTY_W-1:0]  out_duty_b2,
  output logic                         out_is_armed,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [hbsd_pkg::ADDR_W-1:0]  paddr,
  input  logic [hbsd_pkg::DATA_W-1:0]  pwdata,
  output logic [hbsd_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);
  import hbsd_pkg::*;

  hbsd_cfg_t          cfg;
  logic               in_v_r;
  logic               op_r;
  logic [TIME_W-1:0]  now_r;
  logic [STICK_W-1:0] sa_r, sb_r;
  logic               armed_r, armed_nxt;
  logic [TIME_W-1:0]  last_move_r, last_move_nxt;
  logic               out_v_r;
  logic [DUTY_W-1:0]  a1_r, a2_r, b1_r, b2_r;
  logic               advance;
  logic               failsafe;
  logic               stdby;
  logic [STICK_W-1:0] sa_eff, sb_eff;
  logic [DUTY_W-1:0]  a1, a2, b1, b2, sleep_c;
  logic               moved_a, moved_b;
  logic [TIME_W-1:0]  elapsed;

  assign pready = 1'b1;

  hbsd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  // handshake: input stage moves on when the result register is free or drains
  assign advance  = in_v_r & (~out_v_r | out_ready);
  assign in_ready = ~in_v_r | advance;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
    if (in_valid && in_ready) begin
      op_r  <= in_operation;
      now_r <= in_now_ms;
      sa_r  <= in_stick_a;
      sb_r  <= in_stick_b;
    end
  end

  // arming: centred sticks arm, failsafe disarms; disarmed sticks read as centred
  assign failsafe  = (op_r == OP_FAILSAFE);
  assign armed_nxt = failsafe ? 1'b0
                   : (armed_r | ((sa_r == STICK_MID_V) & (sb_r == STICK_MID_V)));
  assign sa_eff    = armed_nxt ? sa_r : STICK_MID_V;
  assign sb_eff    = armed_nxt ? sb_r : STICK_MID_V;

  // standby test against the movement time before this beat
  assign elapsed = now_r - last_move_r;
  assign stdby   = elapsed >= TIME_W'(cfg.standby_ms);

  hbsd_bridge u_bridge_a (
    .stick (sa_eff),
    .stdby (stdby),
    .cfg   (cfg),
    .leg1  (a1),
    .leg2  (a2),
    .moved (moved_a)
  );

  hbsd_bridge u_bridge_b (
    .stick (sb_eff),
    .stdby (stdby),
    .cfg   (cfg),
    .leg1  (b1),
    .leg2  (b2),
    .moved (moved_b)
  );

  assign sleep_c = clamp_duty($signed(CALC_W'(cfg.sleep_duty)));

  // movement time
  always_comb begin
    if (failsafe) begin
      last_move_nxt = '0;
    end else if (moved_a | moved_b) begin
      last_move_nxt = now_r;
    end else begin
      last_move_nxt = last_move_r;
    end
  end

  // state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r     <= 1'b0;
      last_move_r <= '0;
      out_v_r     <= 1'b0;
    end else begin
      if (advance) begin
        armed_r     <= armed_nxt;
        last_move_r <= last_move_nxt;
        out_v_r     <= 1'b1;
      end else if (out_ready) begin
        out_v_r     <= 1'b0;
      end
    end
    if (advance) begin
      a1_r <= failsafe ? sleep_c : a1;
      a2_r <= failsafe ? sleep_c : a2;
      b1_r <= failsafe ? sleep_c : b1;
      b2_r <= failsafe ? sleep_c : b2;
    end
  end

  assign out_valid    = out_v_r;
  assign out_duty_a1  = a1_r;
  assign out_duty_a2  = a2_r;
  assign out_duty_b1  = b1_r;
  assign out_duty_b2  = b2_r;
  assign out_is_armed = armed_r;

  // failsafe leaves the block disarmed with the movement time cleared
  a_failsafe_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && op_r == OP_FAILSAFE) |=> (!armed_r && last_move_r == '0))
    else $error("failsafe did not clear arming state");

  // an empty result register never holds off the input side
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_v_r) |-> in_ready)
    else $error("input stalled with empty result register");

  // every duty shown stays within the duty limit
  a_duty_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (a1_r <= DUTY_W'(DUTY_LIMIT) && a2_r <= DUTY_W'(DUTY_LIMIT) &&
                 b1_r <= DUTY_W'(DUTY_LIMIT) && b2_r <= DUTY_W'(DUTY_LIMIT)))
    else $error("duty above limit");

  // a stalled result keeps the arming state it was produced with
  a_armed_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_ready) |=> $stable(armed_r))
    else $error("arming state changed under a stalled result");

endmodule
